FILE: hdl/mpps_pkg.sv
// ----------------------------------------------------------------------------
// mpps_pkg
// Shared types and constants for the multi-phase PWM sequencer.
// ----------------------------------------------------------------------------
package mpps_pkg;

  // Table geometry
  localparam int PHASES     = 16;
  localparam int WAVES      = 8;
  localparam int PH_W       = $clog2(PHASES);
  localparam int CNT_W      = $clog2(PHASES + 1);
  localparam int WAVE_LIM   = (WAVES < 8) ? WAVES : 8;

  // Fixed field widths
  localparam int IDX_W      = 4;
  localparam int FRAC_W     = 17;
  localparam int PINS_W     = 8;
  localparam int TIME_W     = 32;
  localparam int APPLIED_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = FRAC_W + TIME_W;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

  // Signed 32-bit wait limits, held at the width of the wait sum
  localparam logic signed [34:0] WAIT_MAX = 35'sd2147483647;
  localparam logic signed [34:0] WAIT_MIN = -35'sd2147483648;

  // Event queue depth
  localparam int QDEPTH     = 4;
  localparam int QA_W       = $clog2(QDEPTH);
  localparam int QC_W       = $clog2(QDEPTH + 1);

  // Item commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SWITCH = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_WAIT  = 2'd2;

  // Classified switch event handed from front to back
  typedef struct packed {
    logic              paused;
    logic [PINS_W-1:0] pins;
    logic [PH_W-1:0]   phase;
    logic [FRAC_W-1:0] frac;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] now;
  } ev_t;

endpackage

FILE: hdl/mpps_front.sv
// ----------------------------------------------------------------------------
// mpps_front
// Takes input beats, writes the phase table, tracks phase/base/period state
// and emits one classified event per switch beat.
// ----------------------------------------------------------------------------
module mpps_front
  import mpps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  acc,
  input  logic                  cmd,
  input  logic [IDX_W-1:0]      entry_index,
  input  logic [FRAC_W-1:0]     switch_fraction,
  input  logic [PINS_W-1:0]     entry_pins,
  input  logic [TIME_W-1:0]     now_time,
  input  logic [TIME_W-1:0]     period_ticks,
  input  logic                  paused,
  output logic                  push,
  output ev_t                   ev
);

  logic [4:0]             phase_count_r;
  logic [3:0]             wave_count_r;
  logic [CFG_DATA_W-1:0]  pause_wait_r;

  logic [FRAC_W-1:0]      sw_tab_r [PHASES];
  logic [PINS_W-1:0]      pin_tab_r [PHASES];

  logic [PH_W-1:0]        pos_r, pos_nxt;
  logic [TIME_W-1:0]      base_r, base_nxt;
  logic [TIME_W-1:0]      per_r, per_nxt;
  logic                   pvalid_r, pvalid_nxt;

  logic [CNT_W-1:0]       count;
  logic [PH_W-1:0]        pos;
  logic [CNT_W-1:0]       pos_inc;
  logic [PH_W-1:0]        applied;
  logic [TIME_W-1:0]      base_use, per_use;
  logic [PINS_W-1:0]      mask;
  logic                   is_switch;
  logic                   do_pause;

  function automatic logic [PINS_W-1:0] wave_mask(input logic [3:0] wc);
    logic [3:0] w;
    logic [PINS_W-1:0] m;
    w = wc;
    if (w < 4'd1) w = 4'd1;
    if (w > 4'(WAVE_LIM)) w = 4'(WAVE_LIM);
    for (int i = 0; i < PINS_W; i++) begin
      m[i] = (4'(i) < w);
    end
    return m;
  endfunction

  // Phase count clamped to 2..PHASES
  always_comb begin
    if (phase_count_r < 5'd2) begin
      count = CNT_W'(2);
    end else if (32'(phase_count_r) > 32'(PHASES)) begin
      count = CNT_W'(PHASES);
    end else begin
      count = CNT_W'(phase_count_r);
    end
  end

  assign mask      = wave_mask(wave_count_r);
  assign is_switch = acc && (cmd == CMD_SWITCH);
  // stale position after the count was lowered restarts at phase 0
  assign pos       = (CNT_W'(pos_r) >= count) ? '0 : pos_r;
  assign do_pause  = (pos == '0) && paused;
  assign applied   = (pos == '0) ? PH_W'(count - CNT_W'(1)) : pos - PH_W'(1);
  assign pos_inc   = CNT_W'(pos) + CNT_W'(1);

  always_comb begin
    base_use   = base_r;
    per_use    = per_r;
    pvalid_nxt = pvalid_r;
    if ((pos == '0) && (!pvalid_r || (per_r != period_ticks))) begin
      base_use   = now_time;
      per_use    = period_ticks;
      pvalid_nxt = 1'b1;
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    base_nxt = base_r;
    per_nxt  = per_r;
    if (is_switch) begin
      if (do_pause) begin
        pos_nxt = pos;
      end else begin
        per_nxt = per_use;
        if (pos_inc >= count) begin
          pos_nxt  = '0;
          base_nxt = base_use + per_use;
        end else begin
          pos_nxt  = PH_W'(pos_inc);
          base_nxt = base_use;
        end
      end
    end
  end

  // A pause is sent as a zero-fraction event whose base is the pause wait,
  // so the back end computes wait = pause_wait with no special path.
  always_comb begin
    push = is_switch;
    if (do_pause) begin
      ev.paused = 1'b1;
      ev.pins   = '0;
      ev.phase  = '0;
      ev.frac   = '0;
      ev.period = '0;
      ev.base   = TIME_W'(pause_wait_r);
      ev.now    = '0;
    end else begin
      ev.paused = 1'b0;
      ev.pins   = pin_tab_r[applied] & mask;
      ev.phase  = applied;
      ev.frac   = sw_tab_r[pos];
      ev.period = per_use;
      ev.base   = base_use;
      ev.now    = now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_count_r <= 5'd2;
      wave_count_r  <= 4'd1;
      pause_wait_r  <= CFG_DATA_W'(1000);
      pos_r         <= '0;
      base_r        <= '0;
      per_r         <= '0;
      pvalid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PHASE_COUNT: phase_count_r <= cfg_wdata[4:0];
          CFG_WAVE_COUNT:  wave_count_r  <= cfg_wdata[3:0];
          CFG_PAUSE_WAIT:  pause_wait_r  <= cfg_wdata;
          default: ;
        endcase
      end
      pos_r  <= pos_nxt;
      base_r <= base_nxt;
      per_r  <= per_nxt;
      if (is_switch && !do_pause) begin
        pvalid_r <= pvalid_nxt;
      end
    end
  end

  // Table writes; entries past the table are dropped
  always_ff @(posedge clk) begin
    if (acc && (cmd == CMD_LOAD) && (32'(entry_index) < 32'(PHASES))) begin
      sw_tab_r[PH_W'(entry_index)]  <= (switch_fraction > FRAC_ONE) ? FRAC_ONE
                                                                     : switch_fraction;
      pin_tab_r[PH_W'(entry_index)] <= entry_pins;
    end
  end

endmodule

FILE: hdl/mpps_queue.sv
// ----------------------------------------------------------------------------
// mpps_queue
// Small FIFO of classified events between front and back.
// ----------------------------------------------------------------------------
module mpps_queue
  import mpps_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  ev_t  din,
  input  logic pop,
  output ev_t  dout,
  output logic full,
  output logic empty
);

  ev_t             mem_r [QDEPTH];
  logic [QA_W-1:0] wp_r, rp_r;
  logic [QC_W-1:0] cnt_r;

  assign full  = (cnt_r == QC_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (32'(wp_r) == QDEPTH - 1) ? '0 : wp_r + QA_W'(1);
      end
      if (pop) begin
        rp_r <= (32'(rp_r) == QDEPTH - 1) ? '0 : rp_r + QA_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QC_W'(1);
        2'b01:   cnt_r <= cnt_r - QC_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

FILE: hdl/mpps_back.sv
// ----------------------------------------------------------------------------
// mpps_back
// Two-stage event pipe: fraction x period multiply, then wait sum,
// saturation and the output register.
// ----------------------------------------------------------------------------
module mpps_back
  import mpps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  ev_t                    q_dout,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PINS_W-1:0]      out_pin_levels,
  output logic [APPLIED_W-1:0]   out_applied_phase,
  output logic signed [31:0]     out_wait_ticks,
  output logic                   out_paused_out
);

  logic              s1_v_r;
  logic [PROD_W-1:0] s1_prod_r;
  logic [TIME_W-1:0] s1_base_r, s1_now_r;
  logic [PINS_W-1:0] s1_pins_r;
  logic [PH_W-1:0]   s1_phase_r;
  logic              s1_paused_r;

  logic              out_valid_r;
  logic [PINS_W-1:0] pins_r;
  logic [APPLIED_W-1:0] phase_r;
  logic signed [31:0] wait_r, wait_nxt;
  logic              paused_r;

  logic              s2_load, s1_adv;
  logic [32:0]       offset;
  logic signed [34:0] sum;

  assign s2_load = !out_valid_r || !out_stall;
  assign s1_adv  = !s1_v_r || s2_load;
  assign q_pop   = !q_empty && s1_adv;

  // offset never exceeds the period, so bits above 48 are not needed
  assign offset = s1_prod_r[PROD_W-1:16];
  assign sum    = $signed({3'b000, s1_base_r}) + $signed({2'b00, offset})
                - $signed({3'b000, s1_now_r});

  always_comb begin
    if (sum > WAIT_MAX) begin
      wait_nxt = 32'sh7FFF_FFFF;
    end else if (sum < WAIT_MIN) begin
      wait_nxt = 32'sh8000_0000;
    end else begin
      wait_nxt = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= q_pop;
      end
      if (s2_load) begin
        out_valid_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_prod_r   <= PROD_W'(q_dout.frac) * PROD_W'(q_dout.period);
      s1_base_r   <= q_dout.base;
      s1_now_r    <= q_dout.now;
      s1_pins_r   <= q_dout.pins;
      s1_phase_r  <= q_dout.phase;
      s1_paused_r <= q_dout.paused;
    end
    if (s2_load && s1_v_r) begin
      pins_r   <= s1_pins_r;
      phase_r  <= APPLIED_W'(s1_phase_r);
      wait_r   <= wait_nxt;
      paused_r <= s1_paused_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pin_levels    = pins_r;
  assign out_applied_phase = phase_r;
  assign out_wait_ticks    = wait_r;
  assign out_paused_out    = paused_r;

endmodule

FILE: hdl/multi_phase_pwm_sequencer_top.sv
// ----------------------------------------------------------------------------
// multi_phase_pwm_sequencer_top
// Phase-table PWM sequencer: load beats fill the table, switch beats return
// pin levels and the signed wait until the next switch.
// ----------------------------------------------------------------------------
//  channel | handshake          | direction | beat contents
//  --------+--------------------+-----------+-------------------------------
//  in_     | in_valid/in_stall  | in        | cmd, index, fraction, pins,
//          |                    |           | now, period, paused
//  out_    | out_valid/out_stall| out       | pin levels, phase, wait, paused
//  cfg_    | cfg_we             | in        | index + 16-bit write data
//
// One beat per cycle sustained while the queue is not full. A switch beat passes
// through the queue write, multiply stage and output register; loads give no result.
// With out_ stalled, in_ takes six switch beats (four queued, one in the
// multiply stage, one in the output register); in_stall is the queue-full flag.
// Reset is synchronous on rst_n; the phase table has no reset and must be
// loaded before the entries it uses are reached.
// ----------------------------------------------------------------------------
module multi_phase_pwm_sequencer_top
  import mpps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input beats
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cmd,
  input  logic [IDX_W-1:0]      in_entry_index,
  input  logic [FRAC_W-1:0]     in_switch_fraction,
  input  logic [PINS_W-1:0]     in_entry_pins,
  input  logic [TIME_W-1:0]     in_now_time,
  input  logic [TIME_W-1:0]     in_period_ticks,
  input  logic                  in_paused,
  // result beats
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PINS_W-1:0]     out_pin_levels,
  output logic [APPLIED_W-1:0]  out_applied_phase,
  output logic signed [31:0]    out_wait_ticks,
  output logic                  out_paused_out
);

  logic in_acc;
  logic q_push, q_pop, q_full, q_empty;
  ev_t  q_din, q_dout;

  // Only a full queue holds off the input; loads never touch the queue but
  // are held too so that beat order stays simple.
  assign in_stall = q_full;
  assign in_acc   = in_valid && !in_stall;

  // Front: table writes, phase/base/period tracking, event classification
  mpps_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .acc             (in_acc),
    .cmd             (in_cmd),
    .entry_index     (in_entry_index),
    .switch_fraction (in_switch_fraction),
    .entry_pins      (in_entry_pins),
    .now_time        (in_now_time),
    .period_ticks    (in_period_ticks),
    .paused          (in_paused),
    .push            (q_push),
    .ev              (q_din)
  );

  // Decoupling queue
  mpps_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back: multiply, wait sum with saturation, output register
  mpps_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_dout            (q_dout),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pin_levels    (out_pin_levels),
    .out_applied_phase (out_applied_phase),
    .out_wait_ticks    (out_wait_ticks),
    .out_paused_out    (out_paused_out)
  );

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for multi_phase_pwm_sequencer_top. A directed table
// loads the whole phase table and hits pause, period restart, wrap and
// wait saturation. Random runs under several register settings follow.
// Each switch beat is scored against a hand-written result or the in-bench model.
// ----------------------------------------------------------------------------
module testbench;
  import mpps_pkg::*;

  localparam int DIRECTED_ROWS   = 25;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int DRAIN_CYCLES    = 8;    // pipeline is 3 deep, keep some margin
  localparam int HOLD_CYCLES     = 80;   // long out_ hold-off, fills the event queue
  localparam int WATCHDOG_LIMIT  = 1000;

  // one input beat, field per port
  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  entry_index;
    logic [FRAC_W-1:0] switch_fraction;
    logic [PINS_W-1:0] entry_pins;
    logic [TIME_W-1:0] now_time;
    logic [TIME_W-1:0] period_ticks;
    logic              paused;
  } seq_beat_t;

  // one result beat
  typedef struct packed {
    logic [PINS_W-1:0]    pin_levels;
    logic [APPLIED_W-1:0] applied_phase;
    logic [31:0]          wait_ticks;
    logic                 paused_out;
  } seq_result_t;

  // directed row: a beat, plus a hand-written result where it is obvious
  typedef struct packed {
    logic        typed;
    seq_result_t res;
    seq_beat_t   beat;
  } directed_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_cmd;
  logic [IDX_W-1:0]      in_entry_index;
  logic [FRAC_W-1:0]     in_switch_fraction;
  logic [PINS_W-1:0]     in_entry_pins;
  logic [TIME_W-1:0]     in_now_time;
  logic [TIME_W-1:0]     in_period_ticks;
  logic                  in_paused;
  logic                  out_valid;
  logic                  out_stall;
  logic [PINS_W-1:0]     out_pin_levels;
  logic [APPLIED_W-1:0]  out_applied_phase;
  logic signed [31:0]    out_wait_ticks;
  logic                  out_paused_out;

  multi_phase_pwm_sequencer_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_entry_index     (in_entry_index),
    .in_switch_fraction (in_switch_fraction),
    .in_entry_pins      (in_entry_pins),
    .in_now_time        (in_now_time),
    .in_period_ticks    (in_period_ticks),
    .in_paused          (in_paused),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pin_levels     (out_pin_levels),
    .out_applied_phase  (out_applied_phase),
    .out_wait_ticks     (out_wait_ticks),
    .out_paused_out     (out_paused_out)
  );

  // --------------------------------------------------------------------------
  // Sequencer model state: phase table, cycle timing, register copies
  // --------------------------------------------------------------------------
  logic [FRAC_W-1:0] ph_frac [PHASES];
  logic [PINS_W-1:0] ph_pins [PHASES];
  logic [PH_W-1:0]   cur_phase;
  logic [TIME_W-1:0] cyc_base;
  logic [TIME_W-1:0] cyc_period;
  logic              cyc_period_set;
  logic [4:0]        set_phase_count;
  logic [3:0]        set_wave_count;
  logic [15:0]       set_pause_wait;

  seq_result_t pending_results [$];   // results owed by the block, oldest first
  int          error_count = 0;

  // stimulus shaping
  bit              steady = 1'b0;       // no idling on either side
  bit              hold_request = 1'b0; // receiver does one long hold-off
  logic [TIME_W-1:0] run_now = '0;
  logic [TIME_W-1:0] run_period = 32'd1000;
  int              last_wait = 0;

  // Apply one beat to the model. Loads update the table and return 0;
  // switch beats fill r and return 1.
  function automatic bit sequence_step(input seq_beat_t b, output seq_result_t r);
    int          cnt;
    int          wv;
    int          applied;
    int          nxt;
    logic [7:0]  mask;
    logic [63:0] offset;
    longint      diff;
    r = '0;
    if (b.cmd == CMD_LOAD) begin
      if (int'(b.entry_index) < PHASES) begin
        ph_frac[b.entry_index] = (b.switch_fraction > FRAC_ONE) ? FRAC_ONE
                                                                : b.switch_fraction;
        ph_pins[b.entry_index] = b.entry_pins;
      end
      return 1'b0;
    end

    // out-of-range counts clamp
    cnt = int'(set_phase_count);
    if (cnt < 2) cnt = 2;
    if (cnt > PHASES) cnt = PHASES;
    wv = int'(set_wave_count);
    if (wv < 1) wv = 1;
    if (wv > WAVE_LIM) wv = WAVE_LIM;
    mask = 8'((9'd1 << wv) - 9'd1);

    // count was lowered under a running position
    if (int'(cur_phase) >= cnt) cur_phase = '0;

    if (cur_phase == '0) begin
      if (b.paused) begin
        r.wait_ticks = {16'd0, set_pause_wait};
        r.paused_out = 1'b1;
        return 1'b1;
      end
      if (!cyc_period_set || cyc_period != b.period_ticks) begin
        cyc_base       = b.now_time;
        cyc_period     = b.period_ticks;
        cyc_period_set = 1'b1;
      end
    end

    applied = (cur_phase == '0) ? cnt - 1 : int'(cur_phase) - 1;
    offset  = (64'(ph_frac[cur_phase]) * 64'(cyc_period)) >> 16;
    diff    = longint'({32'd0, cyc_base}) + longint'(offset)
            - longint'({32'd0, b.now_time});
    if (diff > 64'sd2147483647) r.wait_ticks = 32'h7FFF_FFFF;
    else if (diff < -64'sd2147483648) r.wait_ticks = 32'h8000_0000;
    else r.wait_ticks = diff[31:0];
    r.pin_levels    = ph_pins[applied] & mask;
    r.applied_phase = APPLIED_W'(applied);

    nxt = int'(cur_phase) + 1;
    if (nxt >= cnt) begin
      cur_phase = '0;
      cyc_base  = cyc_base + cyc_period;   // wraps mod 2^32
    end else begin
      cur_phase = PH_W'(nxt);
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table: after-reset pause, full table load (fraction above one,
  // extremes of pins), restart, ignored pause, both saturation ends, max and
  // zero periods. Reset register values apply (2 phases, 1 wave, wait 1000).
  // --------------------------------------------------------------------------
  function automatic directed_row_t directed_row(input int n);
    directed_row_t r;
    int            k;
    r = '0;
    r.beat.cmd = CMD_SWITCH;
    k = n - 1;
    if (n >= 1 && n <= PHASES) begin
      r.beat.cmd         = CMD_LOAD;
      r.beat.entry_index = IDX_W'(k);
      case (k)
        0:       begin r.beat.switch_fraction = '0;           r.beat.entry_pins = 8'hFF; end
        1:       begin r.beat.switch_fraction = 17'h1FFFF;    r.beat.entry_pins = 8'hFF; end
        2:       begin r.beat.switch_fraction = FRAC_ONE;     r.beat.entry_pins = 8'h00; end
        15:      begin r.beat.switch_fraction = 17'd65535;    r.beat.entry_pins = 8'h5A; end
        default: begin
          r.beat.switch_fraction = FRAC_W'(k * 4099);
          r.beat.entry_pins      = PINS_W'(k * 29);
        end
      endcase
      return r;
    end
    case (n)
      0: begin   // pause at phase 0 straight out of reset
        r.beat.paused = 1'b1;
        r.typed = 1'b1;
        r.res   = '{pin_levels: 8'h00, applied_phase: 4'd0, wait_ticks: 32'd1000,
                    paused_out: 1'b1};
      end
      17: begin  // first running event restarts the base, entry 0 has fraction 0
        r.beat.now_time = 32'd1000; r.beat.period_ticks = 32'd65536;
        r.typed = 1'b1;
        r.res   = '{pin_levels: 8'h01, applied_phase: 4'd1, wait_ticks: 32'd0,
                    paused_out: 1'b0};
      end
      18: begin  // pause request away from phase 0 is ignored
        r.beat.now_time = 32'd1000; r.beat.period_ticks = 32'd65536; r.beat.paused = 1'b1;
      end
      19: begin  // now far past the base: negative saturation
        r.beat.now_time = 32'hFFFF_FFFF; r.beat.period_ticks = 32'd65536;
        r.typed = 1'b1;
        r.res   = '{pin_levels: 8'h01, applied_phase: 4'd1, wait_ticks: 32'h8000_0000,
                    paused_out: 1'b0};
      end
      20: begin r.beat.now_time = 32'd0; r.beat.period_ticks = 32'hFFFF_FFFF; end
      21: begin r.beat.now_time = 32'd5; r.beat.period_ticks = 32'hFFFF_FFFF; end
      22: begin  // full fraction of max period: positive saturation
        r.beat.now_time = 32'd0; r.beat.period_ticks = 32'hFFFF_FFFF;
        r.typed = 1'b1;
        r.res   = '{pin_levels: 8'h01, applied_phase: 4'd0, wait_ticks: 32'h7FFF_FFFF,
                    paused_out: 1'b0};
      end
      23: begin r.beat.now_time = 32'd7; r.beat.period_ticks = 32'd0; end
      default: begin r.beat.now_time = 32'd0; r.beat.period_ticks = 32'd0; r.beat.paused = 1'b1; end
    endcase
    return r;
  endfunction

  // Random beat. Most are switch events whose time follows the predicted
  // switch points under a steady period; some change the period, some jump
  // time anywhere (saturation), a few pause or reload a table entry.
  function automatic seq_beat_t random_beat();
    seq_beat_t   b;
    int unsigned pick;
    int unsigned advance;
    b.cmd             = CMD_SWITCH;
    b.entry_index     = IDX_W'($urandom);
    b.switch_fraction = FRAC_W'($urandom);
    b.entry_pins      = PINS_W'($urandom);
    b.now_time        = $urandom;
    b.period_ticks    = $urandom;
    b.paused          = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      b.cmd = CMD_LOAD;
      case ($urandom_range(0, 3))
        0:       b.switch_fraction = '0;
        1:       b.switch_fraction = FRAC_ONE;
        default: ;
      endcase
      return b;
    end
    b.paused = (pick < 13);
    if ($urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 7))
        0:       run_period = $urandom;
        1:       run_period = '0;
        default: run_period = $urandom_range(1, 20000);
      endcase
    end
    b.period_ticks = run_period;
    if ($urandom_range(0, 99) < 85) begin
      advance = (last_wait > 0 && last_wait < 100000) ? last_wait : $urandom_range(0, 500);
      run_now = run_now + advance + $urandom_range(0, 6) - 3;   // small jitter
    end else begin
      run_now = $urandom;
    end
    b.now_time = run_now;
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: present a beat, hold it until accepted, score it, maybe idle.
  // --------------------------------------------------------------------------
  task automatic send_beat(input seq_beat_t b, input logic typed,
                           input seq_result_t typed_res);
    seq_result_t r;
    bit          has_res;
    in_valid           <= 1'b1;
    in_cmd             <= b.cmd;
    in_entry_index     <= b.entry_index;
    in_switch_fraction <= b.switch_fraction;
    in_entry_pins      <= b.entry_pins;
    in_now_time        <= b.now_time;
    in_period_ticks    <= b.period_ticks;
    in_paused          <= b.paused;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    // beat taken at this edge
    has_res = sequence_step(b, r);
    if (has_res) begin
      if (typed) r = typed_res;
      pending_results.push_back(r);
      if (!r.paused_out) last_wait = $signed(r.wait_ticks);
    end
    if (!steady && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Register writes, one per cycle, only while the block is idle.
  task automatic apply_setting(input logic [15:0] pc, input logic [15:0] wc,
                               input logic [15:0] pw);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PHASE_COUNT;
    cfg_wdata <= pc;
    @(posedge clk);
    cfg_index <= CFG_WAVE_COUNT;
    cfg_wdata <= wc;
    @(posedge clk);
    cfg_index <= CFG_PAUSE_WAIT;
    cfg_wdata <= pw;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_phase_count = pc[4:0];
    set_wave_count  = wc[3:0];
    set_pause_wait  = pw;
  endtask

  // Wait for every owed result, then let loads still in flight settle.
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result scoreboard: each accepted out_ beat against the oldest expectation
  // --------------------------------------------------------------------------
  seq_result_t want;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: pins %0h phase %0d wait %0d paused %0b",
               out_pin_levels, out_applied_phase, out_wait_ticks, out_paused_out);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_pin_levels !== want.pin_levels) begin
          $error("pin_levels: expected %0h, got %0h", want.pin_levels, out_pin_levels);
          error_count++;
        end
        if (out_applied_phase !== want.applied_phase) begin
          $error("applied_phase: expected %0d, got %0d", want.applied_phase,
                 out_applied_phase);
          error_count++;
        end
        if (out_wait_ticks !== want.wait_ticks) begin
          $error("wait_ticks: expected %0d, got %0d", $signed(want.wait_ticks),
                 out_wait_ticks);
          error_count++;
        end
        if (out_paused_out !== want.paused_out) begin
          $error("paused_out: expected %0b, got %0b", want.paused_out, out_paused_out);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too many cycles with no beat on any port means a hang
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0) || cfg_we === 1'b1)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    directed_row_t row;
    logic [15:0]   pc;
    logic [15:0]   wc;
    logic [15:0]   pw;

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_PHASE_COUNT;
    cfg_wdata          <= '0;
    in_valid           <= 1'b0;
    in_cmd             <= CMD_LOAD;
    in_entry_index     <= '0;
    in_switch_fraction <= '0;
    in_entry_pins      <= '0;
    in_now_time        <= '0;
    in_period_ticks    <= '0;
    in_paused          <= 1'b0;

    // model state after reset; the table is loaded before any read
    for (int i = 0; i < PHASES; i++) begin
      ph_frac[i] = '0;
      ph_pins[i] = '0;
    end
    cur_phase       = '0;
    cyc_base        = '0;
    cyc_period      = '0;
    cyc_period_set  = 1'b0;
    set_phase_count = 5'd2;
    set_wave_count  = 4'd1;
    set_pause_wait  = 16'd1000;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under the reset register values
    for (int n = 0; n < DIRECTED_ROWS; n++) begin
      row = directed_row(n);
      send_beat(row.beat, row.typed, row.res);
    end
    in_valid <= 1'b0;
    drain();

    // random part: one register setting per phase, extremes first
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      pw = 16'($urandom_range(1, 65535));
      case (ph)
        0: begin pc = 16'd2;  wc = 16'd1;  pw = 16'd1;     end
        1: begin pc = 16'd16; wc = 16'd8;  pw = 16'd65535; end
        2: begin pc = 16'd0;  wc = 16'd0;                  end   // clamp up
        3: begin pc = 16'd31; wc = 16'd15;                 end   // clamp down
        4: begin
          pc = 16'($urandom_range(2, 16));
          wc = 16'($urandom_range(1, 8));
        end
        5: begin   // unused upper data bits set
          pc = {11'($urandom), 5'($urandom_range(2, 16))};
          wc = {12'($urandom), 4'($urandom_range(1, 8))};
        end
        6: begin pc = 16'($urandom); wc = 16'($urandom); end
        default: begin pc = 16'd16; wc = 16'd8; end
      endcase
      apply_setting(pc, wc, pw);
      steady = (ph == RANDOM_PHASES - 1);
      if (ph == 1) hold_request = 1'b1;   // back-pressure all the way to in_
      repeat (ITEMS_PER_PHASE) send_beat(random_beat(), 1'b0, '0);
      in_valid <= 1'b0;
      drain();
    end

    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
